/* hdl/bmd_pkg.sv */
// Shared types and constants for the block median decimator.
`timescale 1ns / 1ps

package bmd_pkg;

    localparam int SAMPLE_W = 24;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        logic load;   // latch candidate from RAM read data
        logic clear;  // zero the rank counters
        logic count;  // compare RAM read data against candidate
    } t_rank_ctl;

endpackage

/* hdl/bmd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bmd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 17
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

/* hdl/bmd_rank_unit.sv */
// Rank counter: holds one candidate and counts samples below / not above it.
`timescale 1ns / 1ps

module bmd_rank_unit #(
    parameter int CNT_W = 5,
    parameter int RANK  = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bmd_pkg::t_rank_ctl i_ctl,
    input  bmd_pkg::t_sample   i_rd_data,
    output bmd_pkg::t_sample   o_cand,
    output logic               o_hit
);

    localparam logic [CNT_W-1:0] RANK_C = CNT_W'(RANK);

    bmd_pkg::t_sample r_cand;
    logic [CNT_W-1:0] r_lt_cnt;
    logic [CNT_W-1:0] r_le_cnt;
    logic [CNT_W-1:0] n_lt_cnt;
    logic [CNT_W-1:0] n_le_cnt;

    always_comb begin
        n_lt_cnt = r_lt_cnt;
        n_le_cnt = r_le_cnt;
        if (i_ctl.clear) begin
            n_lt_cnt = '0;
            n_le_cnt = '0;
        end else if (i_ctl.count) begin
            if (i_rd_data < r_cand) begin
                n_lt_cnt = r_lt_cnt + CNT_W'(1);
            end
            if (i_rd_data <= r_cand) begin
                n_le_cnt = r_le_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lt_cnt <= '0;
            r_le_cnt <= '0;
        end else begin
            r_lt_cnt <= n_lt_cnt;
            r_le_cnt <= n_le_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cand <= i_rd_data;
        end
    end

    assign o_cand = r_cand;
    assign o_hit  = (r_lt_cnt <= RANK_C) && (r_le_cnt > RANK_C);

endmodule

/* hdl/block_median_decimator_core.sv */
// Top level: block median decimator, buffer RAM plus rank-select sequencer.
`timescale 1ns / 1ps

// Collects WINDOW_LEN+1 signed 24-bit samples in a buffer RAM and emits
// the sample of rank WINDOW_LEN/2 (ascending) once per block. Samples of
// a block are taken one per cycle. After the last sample of a block the
// input stalls while the rank search runs: each candidate takes one read
// of the candidate and one sweep through the buffer over its single read
// port, and candidates are tried in buffer order until one has the rank.
// The emit step also waits while the previous result is still pending
// in the output register. Results wait in an output register while the
// next block fills.
module block_median_decimator_core #(
    parameter int WINDOW_LEN = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [23:0]      i_sample,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [23:0]      o_median_value
);

    localparam int DEPTH = WINDOW_LEN + 1;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int RANK  = WINDOW_LEN / 2;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(DEPTH);

    localparam logic [2:0] S_FILL  = 3'd0;
    localparam logic [2:0] S_CAND  = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_SWEEP = 3'd3;
    localparam logic [2:0] S_JUDGE = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0]         r_state;
    logic [2:0]         n_state;
    logic [IDX_W-1:0]   r_fill;
    logic [IDX_W-1:0]   n_fill;
    logic [IDX_W-1:0]   r_cand_idx;
    logic [IDX_W-1:0]   n_cand_idx;
    logic [CNT_W-1:0]   r_scan_idx;
    logic [CNT_W-1:0]   n_scan_idx;
    logic               r_out_valid;
    logic               n_out_valid;
    bmd_pkg::t_sample   r_median;

    logic               in_beat;
    logic               out_beat;
    logic               emit;
    logic [IDX_W-1:0]   rd_addr;
    logic [bmd_pkg::SAMPLE_W-1:0] rd_data;
    bmd_pkg::t_rank_ctl rank_ctl;
    bmd_pkg::t_sample   cand;
    logic               hit;

    assign o_stall  = (r_state != S_FILL);
    assign in_beat  = i_valid && !o_stall;
    assign out_beat = r_out_valid && !i_stall;
    assign emit     = (r_state == S_EMIT) && (!r_out_valid || !i_stall);

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_cand_idx = r_cand_idx;
        n_scan_idx = r_scan_idx;
        rd_addr    = r_cand_idx;
        rank_ctl   = '0;
        case (r_state)
            S_FILL: begin
                if (in_beat) begin
                    if (r_fill == LAST_IDX) begin
                        n_fill     = '0;
                        n_cand_idx = '0;
                        n_state    = S_CAND;
                    end else begin
                        n_fill = r_fill + IDX_W'(1);
                    end
                end
            end
            S_CAND: begin
                rd_addr = r_cand_idx;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                rd_addr        = '0;
                rank_ctl.load  = 1'b1;
                rank_ctl.clear = 1'b1;
                n_scan_idx     = CNT_W'(1);
                n_state        = S_SWEEP;
            end
            S_SWEEP: begin
                rank_ctl.count = 1'b1;
                if (r_scan_idx == SCAN_END) begin
                    n_state = S_JUDGE;
                end else begin
                    rd_addr    = r_scan_idx[IDX_W-1:0];
                    n_scan_idx = r_scan_idx + CNT_W'(1);
                end
            end
            S_JUDGE: begin
                if (hit) begin
                    n_state = S_EMIT;
                end else begin
                    n_cand_idx = r_cand_idx + IDX_W'(1);
                    n_state    = S_CAND;
                end
            end
            S_EMIT: begin
                if (emit) begin
                    n_state = S_FILL;
                end
            end
            default: begin
                n_state = S_FILL;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_beat) begin
            n_out_valid = 1'b0;
        end
        if (emit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_fill      <= '0;
            r_cand_idx  <= '0;
            r_scan_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_cand_idx  <= n_cand_idx;
            r_scan_idx  <= n_scan_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_median <= cand;
        end
    end

    bmd_ram #(
        .WIDTH (bmd_pkg::SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (in_beat),
        .i_wr_addr (r_fill),
        .i_wr_data (i_sample),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    bmd_rank_unit #(
        .CNT_W (CNT_W),
        .RANK  (RANK)
    ) u_rank (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (rank_ctl),
        .i_rd_data (bmd_pkg::t_sample'(rd_data)),
        .o_cand    (cand),
        .o_hit     (hit)
    );

    assign o_valid        = r_out_valid;
    assign o_median_value = r_median;

    // A result appears only out of the emit step.
    a_rise_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EMIT))
        else $error("result raised outside emit");

    // A pending, stalled result is never overwritten by the next block.
    a_emit_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_out_valid && i_stall) |=> (r_state == S_EMIT))
        else $error("emit left while output slot busy");

    // Fill pointer and candidate index stay inside the buffer.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= LAST_IDX) && (r_cand_idx <= LAST_IDX))
        else $error("buffer index out of range");

    // The candidate search ends with a hit before the buffer runs out.
    a_judge_hits_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_JUDGE && r_cand_idx == LAST_IDX) |-> hit)
        else $error("no candidate had the selected rank");

endmodule
